>>> hw/rtl/ptmt_pkg.sv
// Shared types, constants and helpers for the pen-to-mouse event translator.
`default_nettype none
package ptmt_pkg;

   localparam int RING_DEPTH  = 16;
   localparam int RING_IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int POS_W   = 22;
   localparam int SCALE_W = 21;
   localparam int OFS_W   = 16;
   localparam int RAW_W   = 16;
   localparam int PROD_W  = RAW_W + 1 + SCALE_W;
   localparam int FRAC_W  = 16;
   localparam int BTN_W   = 8;
   localparam int KEY_W   = 6;
   localparam int TIME_W  = 32;
   localparam int CNT_W   = 32;
   localparam int INJ_W   = 16;

   localparam logic [2:0] KIND_PEN    = 3'd0;
   localparam logic [2:0] KIND_PEN_UP = 3'd1;
   localparam logic [2:0] KIND_KEY    = 3'd2;
   localparam logic [2:0] KIND_INJECT = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;
   localparam logic [2:0] KIND_RESIZE = 3'd5;

   localparam logic [1:0] CSR_SCALE_X  = 2'd0;
   localparam logic [1:0] CSR_SCALE_Y  = 2'd1;
   localparam logic [1:0] CSR_OFFSET_X = 2'd2;
   localparam logic [1:0] CSR_OFFSET_Y = 2'd3;

   localparam logic signed [SCALE_W-1:0] SCALE_X_RESET  = -21'sd16435;
   localparam logic signed [SCALE_W-1:0] SCALE_Y_RESET  = 21'sd23275;
   localparam logic signed [OFS_W-1:0]   OFFSET_X_RESET = 16'sd253;
   localparam logic signed [OFS_W-1:0]   OFFSET_Y_RESET = -16'sd23;

   localparam logic [BTN_W-1:0] BTN_PEN_MASK  = 8'h1f;
   localparam logic [BTN_W-1:0] BTN_ONE       = 8'h01;
   localparam int               SIDE_KEY_BIT  = 5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PEN,
      OP_PEN_UP,
      OP_KEY,
      OP_INJECT,
      OP_READ,
      OP_RESIZE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PROD_W-1:0]   prod_x;
      logic [PROD_W-1:0]   prod_y;
      logic [KEY_W-1:0]    key_mask;
      logic                key_release;
      logic [INJ_W-1:0]    inject_x;
      logic [INJ_W-1:0]    inject_y;
      logic [BTN_W-1:0]    inject_buttons;
      logic [TIME_W-1:0]   time_ms;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [BTN_W-1:0]  buttons;
      logic [TIME_W-1:0] time_ms;
      logic [CNT_W-1:0]  count;
   } ring_entry_type;

   localparam int RING_W = $bits(ring_entry_type);

   function automatic logic [RING_IDX_W-1:0] ring_next(input logic [RING_IDX_W-1:0] p);
      logic [RING_IDX_W-1:0] r;
      if (p == RING_IDX_W'(RING_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pen_to_mouse_event_translator_top.sv
// Top level of the pen-to-mouse event translator: calibration registers and block wiring.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  kind, raw x/y, key, inject, time
//   rsp      out        rsp_valid/rsp_ready  ready_res, resized, pos x/y, buttons, time
//   csr      in         csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// Non-read transfers retire at one per cycle in the back end unless a read holds
// it; the front end multiplies and registers, then a two-entry queue decouples the
// two halves. A read uses the S_READ state (registered ring RAM read) and waits
// for the response register to drain. Synchronous reset; no clearing pass.
`default_nettype none
module pen_to_mouse_event_translator_top import ptmt_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [2:0]              req_kind,
   input  wire logic [RAW_W-1:0]        req_raw_x,
   input  wire logic [RAW_W-1:0]        req_raw_y,
   input  wire logic [KEY_W-1:0]        req_key_mask,
   input  wire logic                    req_key_release,
   input  wire logic signed [INJ_W-1:0] req_inject_x,
   input  wire logic signed [INJ_W-1:0] req_inject_y,
   input  wire logic [BTN_W-1:0]        req_inject_buttons,
   input  wire logic [TIME_W-1:0]       req_time_ms,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_ready_res,
   output logic                         rsp_resized,
   output logic signed [POS_W-1:0]      rsp_pos_x,
   output logic signed [POS_W-1:0]      rsp_pos_y,
   output logic [BTN_W-1:0]             rsp_buttons_out,
   output logic [TIME_W-1:0]            rsp_event_time,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [SCALE_W-1:0]      csr_data
);

   logic signed [SCALE_W-1:0] scale_x_ff;
   logic signed [SCALE_W-1:0] scale_y_ff;
   logic signed [OFS_W-1:0]   offset_x_ff;
   logic signed [OFS_W-1:0]   offset_y_ff;
   logic                      csr_write;
   logic                      fe_valid;
   logic                      fe_ready;
   item_type                  fe_item;
   logic                      q_valid;
   logic                      q_ready;
   item_type                  q_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= SCALE_X_RESET;
         scale_y_ff  <= SCALE_Y_RESET;
         offset_x_ff <= OFFSET_X_RESET;
         offset_y_ff <= OFFSET_Y_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCALE_X:  scale_x_ff  <= csr_data;
            CSR_SCALE_Y:  scale_y_ff  <= csr_data;
            CSR_OFFSET_X: offset_x_ff <= csr_data[OFS_W-1:0];
            CSR_OFFSET_Y: offset_y_ff <= csr_data[OFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ptmt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_raw_x          (req_raw_x),
      .req_raw_y          (req_raw_y),
      .req_key_mask       (req_key_mask),
      .req_key_release    (req_key_release),
      .req_inject_x       (req_inject_x),
      .req_inject_y       (req_inject_y),
      .req_inject_buttons (req_inject_buttons),
      .req_time_ms        (req_time_ms),
      .scale_x            (scale_x_ff),
      .scale_y            (scale_y_ff),
      .out_valid          (fe_valid),
      .out_ready          (fe_ready),
      .out_item           (fe_item)
   );

   ptmt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_item   (fe_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   ptmt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (q_valid),
      .item_ready      (q_ready),
      .item            (q_item),
      .offset_x        (offset_x_ff),
      .offset_y        (offset_y_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ready_res   (rsp_ready_res),
      .rsp_resized     (rsp_resized),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_buttons_out (rsp_buttons_out),
      .rsp_event_time  (rsp_event_time)
   );

endmodule
`default_nettype wire

>>> hw/rtl/ptmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ptmt_front.sv
// Front end: accepts input transfers, classifies the kind and runs the calibration multiplies.
`default_nettype none
module ptmt_front import ptmt_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [2:0]                req_kind,
   input  wire logic [RAW_W-1:0]          req_raw_x,
   input  wire logic [RAW_W-1:0]          req_raw_y,
   input  wire logic [KEY_W-1:0]          req_key_mask,
   input  wire logic                      req_key_release,
   input  wire logic [INJ_W-1:0]          req_inject_x,
   input  wire logic [INJ_W-1:0]          req_inject_y,
   input  wire logic [BTN_W-1:0]          req_inject_buttons,
   input  wire logic [TIME_W-1:0]         req_time_ms,
   input  wire logic signed [SCALE_W-1:0] scale_x,
   input  wire logic signed [SCALE_W-1:0] scale_y,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output item_type                       out_item
);

   op_type   op;
   item_type item_in;
   item_type item_ff;
   logic     valid_in;
   logic     valid_ff;
   logic     accept;

   always_comb begin
      unique case (req_kind)
         KIND_PEN:    op = OP_PEN;
         KIND_PEN_UP: op = OP_PEN_UP;
         KIND_KEY:    op = OP_KEY;
         KIND_INJECT: op = OP_INJECT;
         KIND_READ:   op = OP_READ;
         KIND_RESIZE: op = OP_RESIZE;
         default:     op = OP_NONE;
      endcase
   end

   always_comb begin
      item_in.op             = op;
      item_in.prod_x         = PROD_W'($signed({1'b0, req_raw_x}) * scale_x);
      item_in.prod_y         = PROD_W'($signed({1'b0, req_raw_y}) * scale_y);
      item_in.key_mask       = req_key_mask;
      item_in.key_release    = req_key_release;
      item_in.inject_x       = req_inject_x;
      item_in.inject_y       = req_inject_y;
      item_in.inject_buttons = req_inject_buttons;
      item_in.time_ms        = req_time_ms;
   end

   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   // unknown kinds are dropped here
   assign valid_in = accept ? (op != OP_NONE) : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ptmt_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none
module ptmt_queue import ptmt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    push;
   logic                    pop;

   function automatic logic [QUEUE_IDX_W-1:0] q_next(input logic [QUEUE_IDX_W-1:0] p);
      logic [QUEUE_IDX_W-1:0] r;
      if (p == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? q_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? q_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_item;
   end

endmodule
`default_nettype wire

>>> hw/rtl/ptmt_back.sv
// Back end: pointer state, button tracking, event ring and read responses.
`default_nettype none
module ptmt_back import ptmt_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_valid,
   output logic                         item_ready,
   input  wire item_type                item,
   input  wire logic signed [OFS_W-1:0] offset_x,
   input  wire logic signed [OFS_W-1:0] offset_y,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_ready_res,
   output logic                         rsp_resized,
   output logic signed [POS_W-1:0]      rsp_pos_x,
   output logic signed [POS_W-1:0]      rsp_pos_y,
   output logic [BTN_W-1:0]             rsp_buttons_out,
   output logic [TIME_W-1:0]            rsp_event_time
);

   typedef enum logic [1:0] {
      S_RUN  = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [POS_W-1:0]       cur_x_ff, cur_x_in;
   logic [POS_W-1:0]       cur_y_ff, cur_y_in;
   logic [BTN_W-1:0]       cur_buttons_ff, cur_buttons_in;
   logic [KEY_W-1:0]       modifier_ff, modifier_in;
   logic [CNT_W-1:0]       update_count_ff, update_count_in;
   logic [TIME_W-1:0]      last_time_ff, last_time_in;
   logic [RING_IDX_W-1:0]  read_ptr_ff, read_ptr_in;
   logic [RING_IDX_W-1:0]  write_ptr_ff, write_ptr_in;
   logic                   ring_full_ff, ring_full_in;
   logic [CNT_W-1:0]       seen_count_ff, seen_count_in;
   logic                   resize_ff, resize_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ready_res_ff, rsp_ready_res_in;
   logic                   rsp_resized_ff, rsp_resized_in;
   logic [POS_W-1:0]       rsp_pos_x_ff, rsp_pos_x_in;
   logic [POS_W-1:0]       rsp_pos_y_ff, rsp_pos_y_in;
   logic [BTN_W-1:0]       rsp_buttons_ff, rsp_buttons_in;
   logic [TIME_W-1:0]      rsp_time_ff, rsp_time_in;

   logic [POS_W-1:0]       cal_x, cal_y;
   logic [POS_W-1:0]       new_x, new_y;
   logic [BTN_W-1:0]       nb;
   logic [BTN_W-1:0]       key_bits;
   logic                   do_track;
   logic                   move;
   logic                   exec;
   logic                   rsp_load;
   logic                   rd_ready;
   logic                   rd_nonempty;
   logic                   ring_we;
   ring_entry_type         ring_wdata;
   ring_entry_type         ring_rdata;
   logic [RING_W-1:0]      ring_rdata_raw;

   ptmt_ram #(
      .WIDTH(RING_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (write_ptr_ff),
      .wr_data (ring_wdata),
      .rd_addr (read_ptr_ff),
      .rd_data (ring_rdata_raw)
   );

   assign ring_rdata = ring_rdata_raw;

   // floor(prod / 2^16) + offset
   assign cal_x = item.prod_x[PROD_W-1:FRAC_W] + {{(POS_W-OFS_W){offset_x[OFS_W-1]}}, offset_x};
   assign cal_y = item.prod_y[PROD_W-1:FRAC_W] + {{(POS_W-OFS_W){offset_y[OFS_W-1]}}, offset_y};
   assign key_bits = {{(BTN_W-KEY_W){1'b0}}, item.key_mask};

   always_comb begin
      do_track    = 1'b0;
      move        = 1'b0;
      new_x       = cal_x;
      new_y       = cal_y;
      nb          = cur_buttons_ff;
      modifier_in = modifier_ff;
      unique case (item.op)
         OP_PEN: begin
            do_track = 1'b1;
            move     = !cal_x[POS_W-1];
            if ((cur_buttons_ff & BTN_PEN_MASK) == '0) begin
               if (modifier_ff != '0) nb = cur_buttons_ff | {{(BTN_W-KEY_W){1'b0}}, modifier_ff};
               else nb = cur_buttons_ff | BTN_ONE;
            end
         end
         OP_PEN_UP: begin
            do_track = 1'b1;
            nb       = cur_buttons_ff & ~BTN_PEN_MASK;
         end
         OP_KEY: begin
            if (item.key_mask[SIDE_KEY_BIT] || cur_buttons_ff[0]) begin
               do_track = 1'b1;
               nb = item.key_release ? (cur_buttons_ff & ~key_bits) : (cur_buttons_ff | key_bits);
            end else if (exec) begin
               modifier_in = item.key_release ? (modifier_ff & ~item.key_mask)
                                              : (modifier_ff | item.key_mask);
            end
         end
         OP_INJECT: begin
            do_track = 1'b1;
            move     = !item.inject_x[INJ_W-1];
            new_x    = {{(POS_W-INJ_W){item.inject_x[INJ_W-1]}}, item.inject_x};
            new_y    = {{(POS_W-INJ_W){item.inject_y[INJ_W-1]}}, item.inject_y};
            nb       = item.inject_buttons;
         end
         default: begin
         end
      endcase
   end

   assign exec       = (state_ff == S_RUN) && item_valid && (item.op != OP_READ);
   assign item_ready = exec || (state_ff == S_READ);
   assign rsp_load   = state_ff == S_READ;
   assign ring_we    = exec && do_track && !ring_full_ff && (nb != cur_buttons_ff);
   assign rd_ready   = (seen_count_ff != update_count_ff) || resize_ff;
   assign rd_nonempty = read_ptr_ff != write_ptr_ff;

   always_comb begin
      ring_wdata.x       = move ? new_x : cur_x_ff;
      ring_wdata.y       = move ? new_y : cur_y_ff;
      ring_wdata.buttons = nb;
      ring_wdata.time_ms = item.time_ms;
      ring_wdata.count   = update_count_ff + 1'b1;
   end

   always_comb begin
      state_in         = state_ff;
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      cur_buttons_in   = cur_buttons_ff;
      update_count_in  = update_count_ff;
      last_time_in     = last_time_ff;
      read_ptr_in      = read_ptr_ff;
      write_ptr_in     = write_ptr_ff;
      ring_full_in     = ring_full_ff;
      seen_count_in    = seen_count_ff;
      resize_in        = resize_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_ready_res_in = rd_ready;
      rsp_resized_in   = rd_ready && resize_ff;
      rsp_pos_x_in     = cur_x_ff;
      rsp_pos_y_in     = cur_y_ff;
      rsp_buttons_in   = cur_buttons_ff;
      rsp_time_in      = last_time_ff;

      unique case (state_ff)
         S_RUN: begin
            if (item_valid && item.op == OP_READ && !rsp_valid_ff) state_in = S_READ;
            if (exec && do_track) begin
               if (move) begin
                  cur_x_in = new_x;
                  cur_y_in = new_y;
               end
               cur_buttons_in  = nb;
               update_count_in = update_count_ff + 1'b1;
               last_time_in    = item.time_ms;
            end
            if (ring_we) begin
               write_ptr_in = ring_next(write_ptr_ff);
               if (ring_next(write_ptr_ff) == read_ptr_ff) ring_full_in = 1'b1;
            end
            if (exec && item.op == OP_RESIZE) resize_in = 1'b1;
         end
         S_READ: begin
            state_in     = S_RUN;
            rsp_valid_in = 1'b1;
            if (rd_ready) begin
               ring_full_in  = 1'b0;
               resize_in     = 1'b0;
               seen_count_in = update_count_ff;
               if (rd_nonempty) begin
                  rsp_pos_x_in   = ring_rdata.x;
                  rsp_pos_y_in   = ring_rdata.y;
                  rsp_buttons_in = ring_rdata.buttons;
                  rsp_time_in    = ring_rdata.time_ms;
                  seen_count_in  = ring_rdata.count;
                  read_ptr_in    = ring_next(read_ptr_ff);
               end
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_RUN;
         cur_x_ff        <= '0;
         cur_y_ff        <= '0;
         cur_buttons_ff  <= '0;
         modifier_ff     <= '0;
         update_count_ff <= '0;
         last_time_ff    <= '0;
         read_ptr_ff     <= '0;
         write_ptr_ff    <= '0;
         ring_full_ff    <= 1'b0;
         seen_count_ff   <= '0;
         resize_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cur_x_ff        <= cur_x_in;
         cur_y_ff        <= cur_y_in;
         cur_buttons_ff  <= cur_buttons_in;
         modifier_ff     <= modifier_in;
         update_count_ff <= update_count_in;
         last_time_ff    <= last_time_in;
         read_ptr_ff     <= read_ptr_in;
         write_ptr_ff    <= write_ptr_in;
         ring_full_ff    <= ring_full_in;
         seen_count_ff   <= seen_count_in;
         resize_ff       <= resize_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ready_res_ff <= rsp_ready_res_in;
         rsp_resized_ff   <= rsp_resized_in;
         rsp_pos_x_ff     <= rsp_pos_x_in;
         rsp_pos_y_ff     <= rsp_pos_y_in;
         rsp_buttons_ff   <= rsp_buttons_in;
         rsp_time_ff      <= rsp_time_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ready_res   = rsp_ready_res_ff;
   assign rsp_resized     = rsp_resized_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_buttons_out = rsp_buttons_ff;
   assign rsp_event_time  = rsp_time_ff;

endmodule
`default_nettype wire
